/* rtl/c3g_pkg.sv */
// Shared constants, types and helpers of the 3x3 grayscale convolution block.
`default_nettype none

package c3g_pkg;

  // Largest image the line stores and counters are sized for.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

  localparam int PIX_W      = 8;
  localparam int SIZE_CFG_W = 11;
  localparam int WEIGHT_W   = 16;
  localparam int ROW_CFG_W  = 3 * WEIGHT_W;
  localparam int CFG_DATA_W = ROW_CFG_W;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_W     = 11;

  // Product of a signed weight and a zero-extended pixel, and the sum of nine.
  localparam int PROD_W = WEIGHT_W + PIX_W + 1;
  localparam int SUM_W  = PROD_W + 4;

  localparam logic [SIZE_CFG_W-1:0] WIDTH_RESET  = SIZE_CFG_W'(320);
  localparam logic [SIZE_CFG_W-1:0] HEIGHT_RESET = SIZE_CFG_W'(240);
  localparam logic [ROW_CFG_W-1:0]  TOP_RESET    = '0;
  localparam logic [ROW_CFG_W-1:0]  MIDDLE_RESET = ROW_CFG_W'(48'h0000_0800_0000);
  localparam logic [ROW_CFG_W-1:0]  BOTTOM_RESET = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_WEIGHTS_TOP    = 3'd2,
    REG_WEIGHTS_MIDDLE = 3'd3,
    REG_WEIGHTS_BOTTOM = 3'd4
  } cfg_reg_t;

  typedef logic [PIX_W-1:0]           pixel_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;

  // Indexed [kernel row][kernel column], row 0 on top, column 0 on the left.
  typedef pixel_t  [2:0][2:0] pix_block_t;
  typedef weight_t [2:0][2:0] kernel_t;

  // One window leaving the line buffer stage.
  typedef struct packed {
    logic              valid;
    logic              interior;
    logic              last;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    pix_block_t        pix;
  } window_item_t;

  // Frame size in use: below 3 acts as 3, above the maximum as the maximum.
  function automatic logic [WID_W-1:0] clamp_width(input logic [SIZE_CFG_W-1:0] v);
    int vi;
    vi = int'(v);
    if (vi < 3) return WID_W'(3);
    if (vi > MAX_WIDTH) return WID_W'(MAX_WIDTH);
    return WID_W'(vi);
  endfunction

  function automatic logic [HGT_W-1:0] clamp_height(input logic [SIZE_CFG_W-1:0] v);
    int vi;
    vi = int'(v);
    if (vi < 3) return HGT_W'(3);
    if (vi > MAX_HEIGHT) return HGT_W'(MAX_HEIGHT);
    return HGT_W'(vi);
  endfunction

endpackage

`default_nettype wire

/* rtl/c3g_ifs.sv */
// Stream interfaces for source pixels and filtered results.
`default_nettype none

interface c3g_pixel_if;
  logic                  valid;
  logic                  ready;
  logic [c3g_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface c3g_result_if;
  logic                      valid;
  logic                      ready;
  logic [c3g_pkg::PIX_W-1:0] pixel_out;
  logic [c3g_pkg::COL_W-1:0] out_column;
  logic [c3g_pkg::ROW_W-1:0] out_row;
  logic                      frame_last;

  modport source (output valid, output pixel_out, output out_column, output out_row,
                  output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input out_column, input out_row,
                  input frame_last, output ready);
endinterface

`default_nettype wire

/* rtl/conv3x3_gray_stream_unit.sv */
// Top level of the streaming 3x3 grayscale convolution block.
//
// Source pixels arrive in raster order on the video channel, one per item,
// and filtered pixels leave on the filtered channel with their column, row
// and a flag on the final interior pixel of each frame. Border pixels produce
// no item, so the output carries (width-2)*(height-2) items per frame.
//
// One pixel is taken per clock unless the output stalls. The line store
// read is registered when a pixel is accepted, then the nine kernel
// products, and then the clamped sum in the result register that drives
// the filtered channel.
//
// Reset (rst, synchronous, active high) clears the position counters and
// the window, and loads a 320x240 frame with an identity kernel. The line
// stores are not cleared; the first two rows of a frame fill them first.
// While the receiver holds ready low with a result waiting, the whole
// pipeline stalls and video.ready drops. Configuration is written through
// cfg_we, cfg_index and cfg_data while no pixel is in flight; indices past
// the last register are ignored.
`default_nettype none

module conv3x3_gray_stream_unit (
  input  logic                               clk,
  input  logic                               rst,
  c3g_pixel_if.sink                          video,
  c3g_result_if.source                       filtered,
  input  logic                               cfg_we,
  input  logic [c3g_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c3g_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [c3g_pkg::SIZE_CFG_W-1:0] image_width;
  logic [c3g_pkg::SIZE_CFG_W-1:0] image_height;
  logic [c3g_pkg::ROW_CFG_W-1:0]  weights_top;
  logic [c3g_pkg::ROW_CFG_W-1:0]  weights_middle;
  logic [c3g_pkg::ROW_CFG_W-1:0]  weights_bottom;

  logic [c3g_pkg::WID_W-1:0]      width;
  logic [c3g_pkg::HGT_W-1:0]      height;
  c3g_pkg::kernel_t               kernel;
  c3g_pkg::window_item_t          item;
  logic                           adv;
  logic                           accept;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= c3g_pkg::WIDTH_RESET;
      image_height   <= c3g_pkg::HEIGHT_RESET;
      weights_top    <= c3g_pkg::TOP_RESET;
      weights_middle <= c3g_pkg::MIDDLE_RESET;
      weights_bottom <= c3g_pkg::BOTTOM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        c3g_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg_data[c3g_pkg::SIZE_CFG_W-1:0];
        c3g_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg_data[c3g_pkg::SIZE_CFG_W-1:0];
        c3g_pkg::REG_WEIGHTS_TOP:    weights_top    <= cfg_data[c3g_pkg::ROW_CFG_W-1:0];
        c3g_pkg::REG_WEIGHTS_MIDDLE: weights_middle <= cfg_data[c3g_pkg::ROW_CFG_W-1:0];
        c3g_pkg::REG_WEIGHTS_BOTTOM: weights_bottom <= cfg_data[c3g_pkg::ROW_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign width  = c3g_pkg::clamp_width(image_width);
  assign height = c3g_pkg::clamp_height(image_height);

  // Each kernel row packs its left weight in the top bits.
  always_comb begin
    for (int kc = 0; kc < 3; kc++) begin
      kernel[0][kc] = weights_top[(2-kc)*c3g_pkg::WEIGHT_W +: c3g_pkg::WEIGHT_W];
      kernel[1][kc] = weights_middle[(2-kc)*c3g_pkg::WEIGHT_W +: c3g_pkg::WEIGHT_W];
      kernel[2][kc] = weights_bottom[(2-kc)*c3g_pkg::WEIGHT_W +: c3g_pkg::WEIGHT_W];
    end
  end

  // All stages move together; the output register decides when.
  assign video.ready = adv;
  assign accept      = video.valid && adv;

  c3g_linebuf u_linebuf (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .adv      (adv),
    .pixel_in (video.pixel_in),
    .width    (width),
    .height   (height),
    .item     (item)
  );

  c3g_filter u_filter (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .kernel (kernel),
    .adv    (adv),
    .result (filtered)
  );

  // The input stalls only behind a result that the receiver has not taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !video.ready |-> (filtered.valid && !filtered.ready))
    else $error("input stalled without a waiting result");

  a_result_after_reset: assert property (@(posedge clk)
    rst |=> !filtered.valid)
    else $error("result presented right after reset");

endmodule

`default_nettype wire

/* rtl/c3g_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module c3g_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/c3g_linebuf.sv */
// Position counters, two line stores and the 3x3 window register.
`default_nettype none

module c3g_linebuf (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         adv,
  input  c3g_pkg::pixel_t              pixel_in,
  input  logic [c3g_pkg::WID_W-1:0]    width,
  input  logic [c3g_pkg::HGT_W-1:0]    height,
  output c3g_pkg::window_item_t        item
);

  logic [c3g_pkg::COL_W-1:0] col_count;
  logic [c3g_pkg::ROW_W-1:0] row_count;
  logic [c3g_pkg::WID_W-1:0] col_plus;
  logic [c3g_pkg::HGT_W-1:0] row_plus;

  // First stage: the item waits here while its line store reads complete.
  logic                      s1_valid;
  logic                      s1_interior;
  logic                      s1_last;
  c3g_pkg::pixel_t           s1_px;
  logic [c3g_pkg::COL_W-1:0] s1_addr;
  logic [c3g_pkg::COL_W-1:0] s1_col;
  logic [c3g_pkg::ROW_W-1:0] s1_row;

  c3g_pkg::pixel_t           upper_q;
  c3g_pkg::pixel_t           lower_q;
  logic                      store_we;

  // Two previous columns, each {top, middle, bottom}.
  logic [3*c3g_pkg::PIX_W-1:0] win_a;
  logic [3*c3g_pkg::PIX_W-1:0] win_b;
  logic [3*c3g_pkg::PIX_W-1:0] col_new;

  assign col_plus = c3g_pkg::WID_W'(col_count) + c3g_pkg::WID_W'(1);
  assign row_plus = c3g_pkg::HGT_W'(row_count) + c3g_pkg::HGT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_plus >= width) begin
        col_count <= '0;
        row_count <= (row_plus >= height) ? '0 : row_plus[c3g_pkg::ROW_W-1:0];
      end else begin
        col_count <= col_plus[c3g_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px       <= pixel_in;
      s1_addr     <= col_count;
      s1_col      <= col_count - c3g_pkg::COL_W'(1);
      s1_row      <= row_count - c3g_pkg::ROW_W'(1);
      s1_interior <= (row_count >= c3g_pkg::ROW_W'(2)) && (col_count >= c3g_pkg::COL_W'(2))
                     && (c3g_pkg::HGT_W'(row_count) < height)
                     && (c3g_pkg::WID_W'(col_count) < width);
      s1_last     <= (row_plus == height) && (col_plus == width);
    end
  end

  // The row above slides into the upper store, the new pixel into the lower.
  assign store_we = s1_valid && adv;

  c3g_ram #(.WIDTH(c3g_pkg::PIX_W), .DEPTH(c3g_pkg::MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (store_we),
    .waddr (s1_addr),
    .wdata (lower_q),
    .re    (accept),
    .raddr (col_count),
    .rdata (upper_q)
  );

  c3g_ram #(.WIDTH(c3g_pkg::PIX_W), .DEPTH(c3g_pkg::MAX_WIDTH)) u_lower (
    .clk   (clk),
    .we    (store_we),
    .waddr (s1_addr),
    .wdata (s1_px),
    .re    (accept),
    .raddr (col_count),
    .rdata (lower_q)
  );

  assign col_new = {upper_q, lower_q, s1_px};

  always_ff @(posedge clk) begin
    if (rst) begin
      win_a <= '0;
      win_b <= '0;
    end else if (store_we) begin
      win_a <= win_b;
      win_b <= col_new;
    end
  end

  always_comb begin
    item.valid    = s1_valid;
    item.interior = s1_interior;
    item.last     = s1_last;
    item.col      = s1_col;
    item.row      = s1_row;
    for (int kr = 0; kr < 3; kr++) begin
      item.pix[kr][0] = win_a[(2-kr)*c3g_pkg::PIX_W +: c3g_pkg::PIX_W];
      item.pix[kr][1] = win_b[(2-kr)*c3g_pkg::PIX_W +: c3g_pkg::PIX_W];
      item.pix[kr][2] = col_new[(2-kr)*c3g_pkg::PIX_W +: c3g_pkg::PIX_W];
    end
  end

  // A store entry is read again only a full row later, never in the cycle it is written.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (store_we && accept) |-> (s1_addr != col_count))
    else $error("line store read and write hit the same column");

  a_accept_reaches_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel did not reach the window stage");

endmodule

`default_nettype wire

/* rtl/c3g_filter.sv */
// Kernel products, their sum, the clamp and the result register.
`default_nettype none

module c3g_filter (
  input  logic                  clk,
  input  logic                  rst,
  input  c3g_pkg::window_item_t item,
  input  c3g_pkg::kernel_t      kernel,
  output logic                  adv,
  c3g_result_if.source          result
);

  logic signed [c3g_pkg::PROD_W-1:0] prod [3][3];
  logic                              p_valid;
  logic                              p_last;
  logic [c3g_pkg::COL_W-1:0]         p_col;
  logic [c3g_pkg::ROW_W-1:0]         p_row;

  logic signed [c3g_pkg::SUM_W-1:0]  sum;
  c3g_pkg::pixel_t                   clamped;

  assign adv = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= item.valid && item.interior;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_last <= item.last;
      p_col  <= item.col;
      p_row  <= item.row;
      for (int kr = 0; kr < 3; kr++) begin
        for (int kc = 0; kc < 3; kc++) begin
          prod[kr][kc] <= c3g_pkg::PROD_W'($signed(kernel[kr][kc])
                          * $signed({1'b0, item.pix[kr][kc]}));
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int kr = 0; kr < 3; kr++) begin
      for (int kc = 0; kc < 3; kc++) begin
        sum = sum + c3g_pkg::SUM_W'(prod[kr][kc]);
      end
    end
    // Floor by the fraction width, then saturate to a gray level.
    if (sum[c3g_pkg::SUM_W-1]) begin
      clamped = '0;
    end else if (sum[c3g_pkg::SUM_W-2:c3g_pkg::FRAC_W+c3g_pkg::PIX_W] != '0) begin
      clamped = '1;
    end else begin
      clamped = sum[c3g_pkg::FRAC_W +: c3g_pkg::PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.pixel_out  <= clamped;
      result.out_column <= p_col;
      result.out_row    <= p_row;
      result.frame_last <= p_last;
    end
  end

  // Interior coordinates are never on the top row or left column.
  a_interior_coords: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (p_col != '0) && (p_row != '0))
    else $error("result carries a border coordinate");

  a_result_moves: assert property (@(posedge clk) disable iff (rst)
    (adv && p_valid) |=> result.valid)
    else $error("finished product sum was not presented");

endmodule

`default_nettype wire
